// ===== rtl/bpst_pkg.sv =====
// ----------------------------------------------------------------------------
// bpst_pkg
// Shared types for the buffer pool state tracker: action codes and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bpst_pkg;

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_MARK    = 2'd1,
        ACT_FETCH   = 2'd2,
        ACT_RELEASE = 2'd3
    } t_action;

    typedef struct packed {
        logic start;
        logic apply;
        logic step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/buffer_pool_state_tracker_top.sv =====
// ----------------------------------------------------------------------------
// buffer_pool_state_tracker_top
// Round-robin buffer pool allocator: allocate, mark ready, fetch ready and
// release over a pool of free, in-use and ready buffers.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Payload
//  in        input      i_in_valid / o_in_ready    i_action, i_buffer_index
//  out       output     o_out_valid / i_out_ready  o_found, o_result_index
//
// Mark ready and release are applied when accepted and need no search.
// Allocate and fetch ready scan 16 buffers per cycle, chunk by chunk from the
// pointer's chunk, and stop at the first chunk with a match or after the last chunk.
// Reset clears every buffer to free and both pointers to zero.
// A stalled output holds the finished result and blocks the next transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module buffer_pool_state_tracker_top #(
    parameter int NUM_BUFFERS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_action,
    input  wire logic [3:0]  i_buffer_index,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_found,
    output logic [3:0]       o_result_index
);
    import bpst_pkg::*;

    t_cmd cmd;
    t_sts sts;

    bpst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    bpst_datapath #(
        .NUM_BUFFERS (NUM_BUFFERS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_action       (i_action),
        .i_buffer_index (i_buffer_index),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_found        (o_found),
        .o_result_index (o_result_index)
    );

endmodule

`default_nettype wire

// ===== rtl/bpst_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpst_ctrl
// Controller: accepts a transaction, sequences the chunked search and hands
// the result to the output register when it is free.
// ----------------------------------------------------------------------------
`default_nettype none

module bpst_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic [1:0]    i_action,
    input  wire bpst_pkg::t_sts i_sts,
    output logic               o_in_ready,
    output bpst_pkg::t_cmd     o_cmd
);
    import bpst_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_REPLY
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   is_search;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign is_search  = (i_action == ACT_ALLOC) || (i_action == ACT_FETCH);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.start = 1'b1;
                    if (is_search) begin
                        n_state = S_SEARCH;
                    end else begin
                        o_cmd.apply = 1'b1;
                        if (i_sts.out_free) begin
                            o_cmd.load_out = 1'b1;
                        end else begin
                            n_state = S_REPLY;
                        end
                    end
                end
            end
            S_SEARCH: begin
                o_cmd.step = 1'b1;
                if (i_sts.done) begin
                    if (i_sts.out_free) begin
                        o_cmd.load_out = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        n_state = S_REPLY;
                    end
                end
            end
            S_REPLY: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bpst_datapath.sv =====
// ----------------------------------------------------------------------------
// bpst_datapath
// Buffer status vectors, search pointers, a chunked circular search and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpst_datapath #(
    parameter int NUM_BUFFERS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [1:0]    i_action,
    input  wire logic [3:0]    i_buffer_index,
    input  wire bpst_pkg::t_cmd i_cmd,
    output bpst_pkg::t_sts     o_sts,
    input  wire logic          i_out_ready,
    output logic               o_out_valid,
    output logic               o_found,
    output logic [3:0]         o_result_index
);
    import bpst_pkg::*;

    localparam int W   = 16;
    localparam int C   = (NUM_BUFFERS + W - 1) / W;
    localparam int TOT = C * W;
    localparam int PW  = $clog2(NUM_BUFFERS);
    localparam int LW  = $clog2(W);
    localparam int CW  = (C > 1) ? $clog2(C) : 1;

    logic [NUM_BUFFERS-1:0] r_in_use;
    logic [NUM_BUFFERS-1:0] r_ready;
    logic [PW-1:0]          r_alloc_ptr;
    logic [PW-1:0]          r_ready_ptr;
    t_action                r_op;
    logic [CW-1:0]          r_chunk;
    logic [CW-1:0]          r_pass;
    logic [LW-1:0]          r_start_lane;
    logic                   r_lo_found;
    logic [PW-1:0]          r_lo_index;
    logic                   r_res_found;
    logic [PW-1:0]          r_res_index;
    logic                   r_out_valid;
    logic                   r_out_found;
    logic [3:0]             r_out_index;

    logic                   n_res_found;
    logic [PW-1:0]          n_res_index;
    logic [TOT-1:0]         match_pad;
    logic [W-1:0]           chunk_bits;
    logic [W-1:0]           mask_ge;
    logic [W-1:0]           hi_vec;
    logic [W-1:0]           lo_vec;
    logic                   hi_any;
    logic                   lo_any;
    logic [LW-1:0]          hi_lane;
    logic [LW-1:0]          lo_lane;
    logic                   first_pass;
    logic                   last_pass;
    logic [PW-1:0]          hi_index;
    logic [PW-1:0]          lo_index_now;
    logic                   lo_found_sel;
    logic [PW-1:0]          lo_index_sel;
    logic                   step_done;
    logic [PW-1:0]          start_ptr;
    logic                   idx_in_range;
    logic [PW-1:0]          idx;

    for (genvar g = 0; g < TOT; g++) begin : g_match
        if (g < NUM_BUFFERS) begin : g_real
            assign match_pad[g] = (r_op == ACT_FETCH) ? r_ready[g]
                                                      : (~r_in_use[g] & ~r_ready[g]);
        end else begin : g_pad
            assign match_pad[g] = 1'b0;
        end
    end

    assign chunk_bits = match_pad[int'(r_chunk) * W +: W];
    assign first_pass = (r_pass == '0);
    assign last_pass  = (r_pass == CW'(C - 1));

    always_comb begin
        for (int l = 0; l < W; l++) begin
            mask_ge[l] = (LW'(l) >= r_start_lane);
        end
    end

    assign hi_vec = first_pass ? (chunk_bits & mask_ge) : chunk_bits;
    assign lo_vec = chunk_bits & ~mask_ge;
    assign hi_any = |hi_vec;
    assign lo_any = |lo_vec;

    always_comb begin
        hi_lane = '0;
        lo_lane = '0;
        for (int l = W - 1; l >= 0; l--) begin
            if (hi_vec[l]) begin
                hi_lane = LW'(l);
            end
            if (lo_vec[l]) begin
                lo_lane = LW'(l);
            end
        end
    end

    assign hi_index     = PW'(int'(r_chunk) * W + int'(hi_lane));
    assign lo_index_now = PW'(int'(r_chunk) * W + int'(lo_lane));
    assign lo_found_sel = first_pass ? lo_any : r_lo_found;
    assign lo_index_sel = first_pass ? lo_index_now : r_lo_index;
    assign step_done    = hi_any || last_pass;

    assign start_ptr    = (t_action'(i_action) == ACT_FETCH) ? r_ready_ptr : r_alloc_ptr;
    assign idx_in_range = (32'(i_buffer_index) < NUM_BUFFERS);
    assign idx          = PW'(i_buffer_index);

    always_comb begin
        n_res_found = r_res_found;
        n_res_index = r_res_index;
        if (i_cmd.start) begin
            n_res_found = 1'b0;
            n_res_index = '0;
        end else if (i_cmd.step && step_done) begin
            n_res_found = hi_any || lo_found_sel;
            if (hi_any) begin
                n_res_index = hi_index;
            end else if (lo_found_sel) begin
                n_res_index = lo_index_sel;
            end else begin
                n_res_index = '0;
            end
        end
    end

    assign o_sts.done     = step_done;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use    <= '0;
            r_ready     <= '0;
            r_alloc_ptr <= '0;
            r_ready_ptr <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.apply && idx_in_range) begin
                case (t_action'(i_action))
                    ACT_MARK: begin
                        if (r_in_use[idx]) begin
                            r_in_use[idx] <= 1'b0;
                            r_ready[idx]  <= 1'b1;
                        end
                    end
                    ACT_RELEASE: begin
                        if (r_ready[idx]) begin
                            r_ready[idx] <= 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.step && step_done && n_res_found) begin
                if (r_op == ACT_ALLOC) begin
                    r_in_use[n_res_index] <= 1'b1;
                    r_alloc_ptr           <= n_res_index;
                end else begin
                    r_ready_ptr <= n_res_index;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_found <= n_res_found;
        r_res_index <= n_res_index;
        if (i_cmd.start) begin
            r_op         <= t_action'(i_action);
            r_chunk      <= CW'(int'(start_ptr) / W);
            r_start_lane <= LW'(int'(start_ptr) % W);
            r_pass       <= '0;
        end else if (i_cmd.step) begin
            if (first_pass) begin
                r_lo_found <= lo_any;
                r_lo_index <= lo_index_now;
            end
            r_chunk <= (r_chunk == CW'(C - 1)) ? '0 : r_chunk + 1'b1;
            r_pass  <= r_pass + 1'b1;
        end
        if (i_cmd.load_out) begin
            r_out_found <= n_res_found;
            r_out_index <= 4'(n_res_index);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_out_found;
    assign o_result_index = r_out_index;

endmodule

`default_nettype wire
